// ===== hw/rtl/mhp_pkg.sv =====
// Shared types, codes and helpers for the MOT header stream parser.
`default_nettype none

package mhp_pkg;

  // Result kinds reported on the output channel
  typedef enum logic [3:0] {
    KIND_CORE       = 4'd0,
    KIND_PARAM      = 4'd1,
    KIND_DATA       = 4'd2,
    KIND_DONE       = 4'd4,
    KIND_CORE_SHORT = 4'd5,
    KIND_SIZE_LOW   = 4'd6,
    KIND_EXT_SHORT  = 4'd7,
    KIND_CUT        = 4'd8
  } kind_t;

  // Parser phases
  typedef enum logic [2:0] {
    PH_CORE = 3'd0,
    PH_HDR  = 3'd1,
    PH_LEN1 = 3'd2,
    PH_LEN2 = 3'd3,
    PH_DATA = 3'd4,
    PH_IDLE = 3'd5
  } phase_t;

  // Length indicator codes (top two bits of the parameter header byte)
  typedef enum logic [1:0] {
    PLI_NONE = 2'd0,
    PLI_ONE  = 2'd1,
    PLI_FOUR = 2'd2,
    PLI_VAR  = 2'd3
  } pli_t;

  // Parameter classes
  localparam logic [2:0] CLASS_CONTENT_NAME = 3'd0;
  localparam logic [2:0] CLASS_EXPIRE       = 3'd1;
  localparam logic [2:0] CLASS_TRIGGER      = 3'd2;
  localparam logic [2:0] CLASS_USER_APP     = 3'd3;
  localparam logic [2:0] CLASS_KNOWN        = 3'd4;
  localparam logic [2:0] CLASS_RESERVED     = 3'd5;

  localparam logic [2:0]  CORE_BYTES      = 3'd7;
  localparam logic [5:0]  ID_CONTENT_NAME = 6'b001100;
  localparam logic [5:0]  ID_EXPIRE       = 6'b000100;
  localparam logic [5:0]  ID_TRIGGER      = 6'b000101;
  localparam logic [5:0]  ID_UAPP_LOW     = 6'b100101;
  // one bit per id that is defined but has no decoder here
  localparam logic [63:0] KNOWN_ID_MASK   = 64'h0000_001B_0003_2E82;

  typedef struct packed {
    kind_t        kind;
    logic [27:0]  body_len;
    logic [12:0]  header_len;
    logic [5:0]   obj_type;
    logic [8:0]   content_subtype;
    logic [5:0]   ext_id;
    logic [2:0]   param_class;
    logic [14:0]  param_length;
    logic [7:0]   param_byte;
    logic         run_last;
  } row_t;

  // Results of one parsed byte, handed from the parser to the result queue
  typedef struct packed {
    logic [1:0] count;
    row_t       row0;
    row_t       row1;
  } step_t;

  function automatic logic [2:0] class_of(input logic [5:0] id);
    logic [2:0] cls;
    priority if (id >= ID_UAPP_LOW)      cls = CLASS_USER_APP;
    else if (id == ID_CONTENT_NAME)      cls = CLASS_CONTENT_NAME;
    else if (id == ID_EXPIRE)            cls = CLASS_EXPIRE;
    else if (id == ID_TRIGGER)           cls = CLASS_TRIGGER;
    else if (KNOWN_ID_MASK[id])          cls = CLASS_KNOWN;
    else                                 cls = CLASS_RESERVED;
    return cls;
  endfunction

  function automatic row_t core_row(input kind_t k, input logic [55:0] shift);
    row_t r;
    r                 = '0;
    r.kind            = k;
    r.body_len        = shift[55:28];
    r.header_len      = shift[27:15];
    r.obj_type        = shift[14:9];
    r.content_subtype = shift[8:0];
    return r;
  endfunction

  function automatic row_t param_row(input kind_t k, input logic [5:0] id);
    row_t r;
    r             = '0;
    r.kind        = k;
    r.ext_id      = id;
    r.param_class = class_of(id);
    return r;
  endfunction

  function automatic row_t plain_row(input kind_t k);
    row_t r;
    r      = '0;
    r.kind = k;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mot_header_stream_parser.sv =====
// Top level of the MOT header stream parser: byte parser plus result queue.
//
//  Channel   Handshake            Payload
//  -------   ------------------   ---------------------------------------------
//  in        in_valid/in_stall    data_byte, buffer_end
//  out       out_valid/out_stall  kind, body_len, header_len, obj_type,
//                                 content_subtype, ext_id, param_class,
//                                 param_length, param_byte, run_last
//
//  One request enters per cycle while the result queue has two free slots; the
//  parser settles each byte in the cycle it is taken, and its results are
//  registered into the result queue, whose head drives the output.
//  The output side drains one result per cycle while out_stall is low, so a
//  byte that yields two results (a result followed by done, by size low or by
//  extension short) takes one more output turn than a byte with one result.
//  Reset clears the parser state and empties the queue at once; no sweep.
//  A stall on the output fills the queue, and in_stall rises when fewer than
//  two slots remain.
`default_nettype none

module mot_header_stream_parser #(
  // result queue depth, 2 to 32; 4 sustains one byte per cycle while the output is not stalled
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        buffer_end,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [3:0]  kind,
  output      logic [27:0] body_len,
  output      logic [12:0] header_len,
  output      logic [5:0]  obj_type,
  output      logic [8:0]  content_subtype,
  output      logic [5:0]  ext_id,
  output      logic [2:0]  param_class,
  output      logic [14:0] param_length,
  output      logic [7:0]  param_byte,
  output      logic        run_last
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  mhp_pkg::step_t step;
  mhp_pkg::row_t  queue [QUEUE_DEPTH];
  mhp_pkg::row_t  head;

  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next, wr_ptr_inc;
  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [1:0]        push_count;
  logic              in_take;
  logic              out_take;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Hold off new requests unless both result slots of a byte are free
  assign in_stall = (fill > FILL_W'(QUEUE_DEPTH - 2));
  assign in_take  = in_valid && !in_stall;
  assign out_valid = (fill != '0);
  assign out_take  = out_valid && !out_stall;

  mhp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step_en    (in_take),
    .data_byte  (data_byte),
    .buffer_end (buffer_end),
    .step       (step)
  );

  assign push_count = in_take ? step.count : 2'd0;
  assign wr_ptr_inc = ptr_inc(wr_ptr);

  // Advance write side by the number of results, read side by one per take
  always_comb begin
    unique case (push_count)
      2'd1:    wr_ptr_next = wr_ptr_inc;
      2'd2:    wr_ptr_next = ptr_inc(wr_ptr_inc);
      default: wr_ptr_next = wr_ptr;
    endcase
    rd_ptr_next = out_take ? ptr_inc(rd_ptr) : rd_ptr;
    fill_next   = fill + FILL_W'(push_count) - FILL_W'(out_take);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      fill   <= fill_next;
    end
  end

  // Result storage: payload only, no reset
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      queue[wr_ptr] <= step.row0;
    end
    if (push_count == 2'd2) begin
      queue[wr_ptr_inc] <= step.row1;
    end
  end

  assign head            = queue[rd_ptr];
  assign kind            = head.kind;
  assign body_len        = head.body_len;
  assign header_len      = head.header_len;
  assign obj_type        = head.obj_type;
  assign content_subtype = head.content_subtype;
  assign ext_id          = head.ext_id;
  assign param_class     = head.param_class;
  assign param_length    = head.param_length;
  assign param_byte      = head.param_byte;
  assign run_last        = head.run_last;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (rd_ptr == wr_ptr))
    else $error("empty queue with pointers apart");

  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (in_take && (step.count == 2'd2) && !out_take) |=>
    (fill == $past(fill) + FILL_W'(2)))
    else $error("queue fill lost a result of a double-result byte");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mhp_parser.sv =====
// Byte parser: header core collection and extension parameter walk.
`default_nettype none

module mhp_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step_en,
  input  wire logic [7:0]    data_byte,
  input  wire logic          buffer_end,
  output mhp_pkg::step_t     step
);

  mhp_pkg::phase_t phase, phase_next, phase_step;
  logic [2:0]  core_count, core_count_next;
  logic [55:0] core_shift, core_shift_next;
  logic [12:0] ext_remaining, ext_remaining_next;
  logic [14:0] field_remaining, field_remaining_next;
  logic [6:0]  length_high, length_high_next;
  logic [5:0]  current_id, current_id_next;

  logic [55:0] shift_new;
  logic [2:0]  count_new;
  logic        core_done;
  logic [12:0] hs;
  logic [12:0] ext_dec;
  logic        ext_zero;
  logic        in_ext;
  logic [5:0]  id_new;
  logic [14:0] field_dec;
  logic        have_len;
  logic [14:0] len;
  logic        do_cut;
  logic        cut;
  logic        accept_len;

  mhp_pkg::row_t r0, r1;
  logic [1:0]    n;

  assign shift_new = {core_shift[47:0], data_byte};
  assign count_new = core_count + 3'd1;
  assign core_done = (count_new == mhp_pkg::CORE_BYTES);
  assign hs        = shift_new[27:15];
  assign ext_dec   = ext_remaining - 13'd1;
  assign ext_zero  = (ext_remaining == 13'd0);
  assign in_ext    = (phase != mhp_pkg::PH_CORE) && (phase != mhp_pkg::PH_IDLE);
  assign id_new    = (phase == mhp_pkg::PH_HDR) ? data_byte[5:0] : current_id;
  assign field_dec = (field_remaining != 15'd0) ? field_remaining - 15'd1 : 15'd0;

  // Decode the length of the current parameter, if this byte settles it
  always_comb begin
    have_len = 1'b0;
    len      = '0;
    do_cut   = 1'b0;
    if (in_ext && !ext_zero) begin
      unique case (phase)
        mhp_pkg::PH_HDR: begin
          unique case (mhp_pkg::pli_t'(data_byte[7:6]))
            mhp_pkg::PLI_NONE: begin
              have_len = 1'b1;
              len      = 15'd0;
            end
            mhp_pkg::PLI_ONE: begin
              have_len = 1'b1;
              len      = 15'd1;
            end
            mhp_pkg::PLI_FOUR: begin
              have_len = 1'b1;
              len      = 15'd4;
            end
            mhp_pkg::PLI_VAR: begin
              do_cut = (ext_dec == 13'd0);
            end
          endcase
        end
        mhp_pkg::PH_LEN1: begin
          if (!data_byte[7]) begin
            have_len = 1'b1;
            len      = {8'd0, data_byte[6:0]};
          end else begin
            do_cut = (ext_dec == 13'd0);
          end
        end
        mhp_pkg::PH_LEN2: begin
          have_len = 1'b1;
          len      = {length_high, data_byte};
        end
        default: begin
        end
      endcase
    end
  end

  assign cut        = do_cut || (have_len && (len > {2'b00, ext_dec}));
  assign accept_len = have_len && !cut;

  // Next state
  always_comb begin
    phase_step           = phase;
    core_count_next      = core_count;
    core_shift_next      = core_shift;
    ext_remaining_next   = ext_remaining;
    field_remaining_next = field_remaining;
    length_high_next     = length_high;
    current_id_next      = current_id;
    if (phase == mhp_pkg::PH_CORE) begin
      core_shift_next = shift_new;
      core_count_next = count_new;
      if (core_done) begin
        ext_remaining_next = hs - {10'd0, mhp_pkg::CORE_BYTES};
        if (hs <= {10'd0, mhp_pkg::CORE_BYTES}) begin
          phase_step = mhp_pkg::PH_IDLE;
        end else begin
          phase_step = mhp_pkg::PH_HDR;
        end
      end
    end else if (in_ext) begin
      if (ext_zero) begin
        phase_step = mhp_pkg::PH_IDLE;
      end else begin
        ext_remaining_next = ext_dec;
        current_id_next    = id_new;
        if (cut) begin
          phase_step = mhp_pkg::PH_IDLE;
        end else if (accept_len) begin
          if (len == 15'd0) begin
            phase_step = (ext_dec == 13'd0) ? mhp_pkg::PH_IDLE : mhp_pkg::PH_HDR;
          end else begin
            field_remaining_next = len;
            phase_step           = mhp_pkg::PH_DATA;
          end
        end else if (phase == mhp_pkg::PH_HDR) begin
          phase_step = mhp_pkg::PH_LEN1;
        end else if (phase == mhp_pkg::PH_LEN1) begin
          length_high_next = data_byte[6:0];
          phase_step       = mhp_pkg::PH_LEN2;
        end else if (phase == mhp_pkg::PH_DATA) begin
          field_remaining_next = field_dec;
          if (field_dec == 15'd0) begin
            phase_step = (ext_dec == 13'd0) ? mhp_pkg::PH_IDLE : mhp_pkg::PH_HDR;
          end
        end
      end
    end
    phase_next = phase_step;
    // a buffer end always rearms for the next header
    if (buffer_end) begin
      phase_next           = mhp_pkg::PH_CORE;
      core_count_next      = '0;
      core_shift_next      = '0;
      ext_remaining_next   = '0;
      field_remaining_next = '0;
      length_high_next     = '0;
      current_id_next      = '0;
    end
  end

  // Result rows
  always_comb begin
    r0 = '0;
    r1 = '0;
    n  = 2'd0;
    if (phase == mhp_pkg::PH_CORE) begin
      if (core_done) begin
        r0 = mhp_pkg::core_row(mhp_pkg::KIND_CORE, shift_new);
        n  = 2'd1;
        if (hs < {10'd0, mhp_pkg::CORE_BYTES}) begin
          r1 = mhp_pkg::plain_row(mhp_pkg::KIND_SIZE_LOW);
          n  = 2'd2;
        end else if (hs == {10'd0, mhp_pkg::CORE_BYTES}) begin
          r1 = mhp_pkg::core_row(mhp_pkg::KIND_DONE, shift_new);
          n  = 2'd2;
        end
      end else if (buffer_end) begin
        r0 = mhp_pkg::plain_row(mhp_pkg::KIND_CORE_SHORT);
        n  = 2'd1;
      end
    end else if (in_ext && !ext_zero) begin
      if (cut) begin
        r0 = mhp_pkg::param_row(mhp_pkg::KIND_CUT, id_new);
        r1 = mhp_pkg::core_row(mhp_pkg::KIND_DONE, core_shift);
        n  = 2'd2;
      end else if (accept_len) begin
        r0              = mhp_pkg::param_row(mhp_pkg::KIND_PARAM, id_new);
        r0.param_length = len;
        n               = 2'd1;
        if ((len == 15'd0) && (ext_dec == 13'd0)) begin
          r1 = mhp_pkg::core_row(mhp_pkg::KIND_DONE, core_shift);
          n  = 2'd2;
        end
      end else if (phase == mhp_pkg::PH_DATA) begin
        r0            = mhp_pkg::param_row(mhp_pkg::KIND_DATA, current_id);
        r0.param_byte = data_byte;
        n             = 2'd1;
        if ((field_dec == 15'd0) && (ext_dec == 13'd0)) begin
          r1 = mhp_pkg::core_row(mhp_pkg::KIND_DONE, core_shift);
          n  = 2'd2;
        end
      end
    end
    // buffer ran out inside the extension: flag it if a slot is left
    if (buffer_end && (phase_step != mhp_pkg::PH_IDLE) &&
        (phase_step != mhp_pkg::PH_CORE)) begin
      if (n == 2'd0) begin
        r0 = mhp_pkg::plain_row(mhp_pkg::KIND_EXT_SHORT);
        n  = 2'd1;
      end else if (n == 2'd1) begin
        r1 = mhp_pkg::plain_row(mhp_pkg::KIND_EXT_SHORT);
        n  = 2'd2;
      end
    end
    if (n == 2'd1) r0.run_last = 1'b1;
    if (n == 2'd2) r1.run_last = 1'b1;
  end

  assign step.count = n;
  assign step.row0  = r0;
  assign step.row1  = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= mhp_pkg::PH_CORE;
      core_count      <= '0;
      core_shift      <= '0;
      ext_remaining   <= '0;
      field_remaining <= '0;
      length_high     <= '0;
      current_id      <= '0;
    end else if (step_en) begin
      phase           <= phase_next;
      core_count      <= core_count_next;
      core_shift      <= core_shift_next;
      ext_remaining   <= ext_remaining_next;
      field_remaining <= field_remaining_next;
      length_high     <= length_high_next;
      current_id      <= current_id_next;
    end
  end

`ifndef SYNTH
  a_core_count_range: assert property (@(posedge clk) disable iff (rst)
    (phase == mhp_pkg::PH_CORE) |-> (core_count != mhp_pkg::CORE_BYTES))
    else $error("core count reached full size while still collecting");

  a_ext_nonzero: assert property (@(posedge clk) disable iff (rst)
    ((phase == mhp_pkg::PH_HDR) || (phase == mhp_pkg::PH_LEN1) ||
     (phase == mhp_pkg::PH_LEN2) || (phase == mhp_pkg::PH_DATA)) |->
    (ext_remaining != 13'd0))
    else $error("extension phase entered with no extension bytes left");

  a_field_fits: assert property (@(posedge clk) disable iff (rst)
    (phase == mhp_pkg::PH_DATA) |->
    ((field_remaining != 15'd0) && (field_remaining <= {2'b00, ext_remaining})))
    else $error("parameter data count out of step with extension count");

  a_last_marks: assert property (@(posedge clk) disable iff (rst)
    (step_en && (step.count == 2'd2)) |-> (step.row1.run_last && !step.row0.run_last))
    else $error("last-result mark on the wrong row");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_mot_header_stream_parser.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the MOT header stream parser: frames in, results checked.
module tb_mot_header_stream_parser;

  // One parsed result, laid out like the output ports
  typedef struct packed {
    logic [3:0]  kind;
    logic [27:0] body_len;
    logic [12:0] header_len;
    logic [5:0]  obj_type;
    logic [8:0]  content_subtype;
    logic [5:0]  ext_id;
    logic [2:0]  param_class;
    logic [14:0] param_length;
    logic [7:0]  param_byte;
    logic        run_last;
  } result_t;

  // One request for the input channel, or a marker that pauses the sender
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drain;
  } request_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_PERIODIC
  } stall_mode_t;

  // Ids 1, 7, 9, 10, 11, 13, 16, 17, 32, 33, 35 and 36: defined, but not decoded here
  localparam logic [63:0] UNDECODED_IDS = 64'h0000_001B_0003_2E82;

  // Stop generating once roughly this many requests are queued
  localparam int REQUEST_TARGET = 780;

  // ---------------------------------------------------------------------------
  // Clock, reset and the block
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        buffer_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  kind;
  logic [27:0] body_len;
  logic [12:0] header_len;
  logic [5:0]  obj_type;
  logic [8:0]  content_subtype;
  logic [5:0]  ext_id;
  logic [2:0]  param_class;
  logic [14:0] param_length;
  logic [7:0]  param_byte;
  logic        run_last;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  mot_header_stream_parser u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .buffer_end      (buffer_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .body_len        (body_len),
    .header_len      (header_len),
    .obj_type        (obj_type),
    .content_subtype (content_subtype),
    .ext_id          (ext_id),
    .param_class     (param_class),
    .param_length    (param_length),
    .param_byte      (param_byte),
    .run_last        (run_last)
  );

  // ---------------------------------------------------------------------------
  // Header parser prediction: its own copy of the parser state
  // ---------------------------------------------------------------------------
  mhp_pkg::phase_t hdr_phase;
  logic [2:0]  hdr_core_count;
  logic [55:0] hdr_core;
  logic [12:0] hdr_ext_left;
  logic [14:0] hdr_field_left;
  logic [6:0]  hdr_len_high;
  logic [5:0]  hdr_id;

  result_t  step_rows[$];         // results of the byte being parsed
  result_t  expected_results[$];  // results still owed by the block
  request_t pending_requests[$];  // requests not yet offered
  logic [7:0] frame_bytes[$];     // header frame under construction
  int       fail_count = 0;
  int       request_count = 0;

  function automatic logic [2:0] class_of_id(input logic [5:0] id);
    if (id >= mhp_pkg::ID_UAPP_LOW) return mhp_pkg::CLASS_USER_APP;
    if (id == mhp_pkg::ID_CONTENT_NAME) return mhp_pkg::CLASS_CONTENT_NAME;
    if (id == mhp_pkg::ID_EXPIRE) return mhp_pkg::CLASS_EXPIRE;
    if (id == mhp_pkg::ID_TRIGGER) return mhp_pkg::CLASS_TRIGGER;
    if (UNDECODED_IDS[id]) return mhp_pkg::CLASS_KNOWN;
    return mhp_pkg::CLASS_RESERVED;
  endfunction

  task automatic clear_parser();
    hdr_phase      = mhp_pkg::PH_CORE;
    hdr_core_count = '0;
    hdr_core       = '0;
    hdr_ext_left   = '0;
    hdr_field_left = '0;
    hdr_len_high   = '0;
    hdr_id         = '0;
  endtask

  // Append one result; core fields and parameter fields only where asked
  task automatic push_row(input mhp_pkg::kind_t k, input bit with_core,
                          input bit with_param, input logic [14:0] len,
                          input logic [7:0] pbyte);
    result_t r;
    r = '0;
    r.kind = k;
    if (with_core) begin
      r.body_len        = hdr_core[55:28];
      r.header_len      = hdr_core[27:15];
      r.obj_type        = hdr_core[14:9];
      r.content_subtype = hdr_core[8:0];
    end
    if (with_param) begin
      r.ext_id      = hdr_id;
      r.param_class = class_of_id(hdr_id);
    end
    r.param_length = len;
    r.param_byte   = pbyte;
    step_rows = {step_rows, r};
  endtask

  task automatic close_header();
    push_row(mhp_pkg::KIND_DONE, 1'b1, 1'b0, '0, '0);
    hdr_phase = mhp_pkg::PH_IDLE;
  endtask

  task automatic cut_param();
    push_row(mhp_pkg::KIND_CUT, 1'b0, 1'b1, '0, '0);
    close_header();
  endtask

  // Length of the current parameter is known: report it, or cut if it overruns
  task automatic take_length(input logic [14:0] len);
    if (len > 15'(hdr_ext_left)) begin
      cut_param();
    end else begin
      push_row(mhp_pkg::KIND_PARAM, 1'b0, 1'b1, len, '0);
      if (len == 0) begin
        if (hdr_ext_left == 0) close_header();
        else hdr_phase = mhp_pkg::PH_HDR;
      end else begin
        hdr_field_left = len;
        hdr_phase      = mhp_pkg::PH_DATA;
      end
    end
  endtask

  // Parse one accepted byte and queue the results it owes
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [12:0] hsize;
    result_t     r;
    step_rows.delete();
    case (hdr_phase)
      mhp_pkg::PH_CORE: begin
        hdr_core       = {hdr_core[47:0], b};
        hdr_core_count = hdr_core_count + 3'd1;
        if (hdr_core_count == mhp_pkg::CORE_BYTES) begin
          hsize = hdr_core[27:15];
          push_row(mhp_pkg::KIND_CORE, 1'b1, 1'b0, '0, '0);
          if (hsize < 13'(mhp_pkg::CORE_BYTES)) begin
            push_row(mhp_pkg::KIND_SIZE_LOW, 1'b0, 1'b0, '0, '0);
            hdr_phase = mhp_pkg::PH_IDLE;
          end else begin
            hdr_ext_left = hsize - 13'(mhp_pkg::CORE_BYTES);
            if (hdr_ext_left == 0) close_header();
            else hdr_phase = mhp_pkg::PH_HDR;
          end
        end else if (last) begin
          push_row(mhp_pkg::KIND_CORE_SHORT, 1'b0, 1'b0, '0, '0);
        end
      end
      mhp_pkg::PH_IDLE: ;
      default: begin
        if (hdr_ext_left == 0) begin
          hdr_phase = mhp_pkg::PH_IDLE;
        end else begin
          hdr_ext_left = hdr_ext_left - 13'd1;
          case (hdr_phase)
            mhp_pkg::PH_HDR: begin
              hdr_id = b[5:0];
              case (mhp_pkg::pli_t'(b[7:6]))
                mhp_pkg::PLI_NONE: take_length(15'd0);
                mhp_pkg::PLI_ONE:  take_length(15'd1);
                mhp_pkg::PLI_FOUR: take_length(15'd4);
                default: begin
                  if (hdr_ext_left == 0) cut_param();
                  else hdr_phase = mhp_pkg::PH_LEN1;
                end
              endcase
            end
            mhp_pkg::PH_LEN1: begin
              if (b[7]) begin
                hdr_len_high = b[6:0];
                if (hdr_ext_left == 0) cut_param();
                else hdr_phase = mhp_pkg::PH_LEN2;
              end else begin
                take_length({8'd0, b[6:0]});
              end
            end
            mhp_pkg::PH_LEN2: take_length({hdr_len_high, b});
            default: begin
              push_row(mhp_pkg::KIND_DATA, 1'b0, 1'b1, '0, b);
              if (hdr_field_left > 0) hdr_field_left = hdr_field_left - 15'd1;
              if (hdr_field_left == 0) begin
                if (hdr_ext_left == 0) close_header();
                else hdr_phase = mhp_pkg::PH_HDR;
              end
            end
          endcase
        end
      end
    endcase
    if (last) begin
      // buffer ended inside the extension: flag it unless two results are out already
      if (hdr_phase != mhp_pkg::PH_IDLE && hdr_phase != mhp_pkg::PH_CORE &&
          step_rows.size() < 2)
        push_row(mhp_pkg::KIND_EXT_SHORT, 1'b0, 1'b0, '0, '0);
      clear_parser();
    end
    foreach (step_rows[i]) begin
      r          = step_rows[i];
      r.run_last = (i == step_rows.size() - 1);
      expected_results = {expected_results, r};
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predict each accepted request, then check each accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      clear_parser();
    end else begin
      if (in_valid && !in_stall) parse_byte(data_byte, buffer_end);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: kind %0d", kind);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind));
          check_field("body_len", 32'(want.body_len), 32'(body_len));
          check_field("header_len", 32'(want.header_len), 32'(header_len));
          check_field("obj_type", 32'(want.obj_type), 32'(obj_type));
          check_field("content_subtype", 32'(want.content_subtype),
                      32'(content_subtype));
          check_field("ext_id", 32'(want.ext_id), 32'(ext_id));
          check_field("param_class", 32'(want.param_class), 32'(param_class));
          check_field("param_length", 32'(want.param_length), 32'(param_length));
          check_field("param_byte", 32'(want.param_byte), 32'(param_byte));
          check_field("run_last", 32'(want.run_last), 32'(run_last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offer requests in bursts with random gaps; hold a stalled request
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;
  bit draining   = 1'b0;

  always @(posedge clk) begin : driver
    request_t req;
    if (rst) begin
      in_valid   <= 1'b0;
      data_byte  <= 8'h00;
      buffer_end <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (draining) begin
        // pause until every owed result has come back
        in_valid <= 1'b0;
        if (expected_results.size() == 0) draining = 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        req = pending_requests.pop_front();
        if (req.drain) begin
          draining = 1'b1;
          in_valid <= 1'b0;
        end else begin
          in_valid   <= 1'b1;
          data_byte  <= req.data;
          buffer_end <= req.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // new burst; about half the bursts follow on with no gap at all
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) < 2) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a changing pattern, with one long hold-off to back up
  // the result queue and push the stall through to the input side
  // ---------------------------------------------------------------------------
  int          rx_cycles    = 0;
  int          holdoff_left = 0;
  stall_mode_t stall_mode   = STALL_NONE;

  always @(posedge clk) begin : receiver
    if (rst) begin
      out_stall <= 1'b0;
      rx_cycles = 0;
    end else begin
      rx_cycles++;
      if (rx_cycles == 300) holdoff_left = 400;
      if (rx_cycles % 160 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
          default:     out_stall <= (rx_cycles % 7) < 4;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b, input logic last);
    request_t r;
    r      = '0;
    r.data = b;
    r.last = last;
    pending_requests = {pending_requests, r};
    request_count++;
  endtask

  // Append one byte to the frame under construction
  task automatic add_byte(input logic [7:0] b);
    frame_bytes = {frame_bytes, b};
  endtask

  // Queue the frame under construction, flagging buffer end on its final byte
  task automatic send_frame();
    foreach (frame_bytes[i]) queue_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frame_bytes.delete();
  endtask

  // Put the 7 core bytes in front of whatever extension is already built
  task automatic add_core(input logic [55:0] core);
    for (int i = 0; i < 7; i++) frame_bytes.push_front(core[8*i +: 8]);
  endtask

  function automatic logic [55:0] random_core(input logic [12:0] hsize);
    return {28'($urandom), hsize, 6'($urandom), 9'($urandom)};
  endfunction

  // Append one well-formed extension parameter with random id and content
  task automatic add_param();
    logic [5:0] id;
    int         plen;
    id = $urandom_range(0, 63);
    case ($urandom_range(0, 4))
      0: begin
        add_byte({mhp_pkg::PLI_NONE, id});
        plen = 0;
      end
      1: begin
        add_byte({mhp_pkg::PLI_ONE, id});
        plen = 1;
      end
      2: begin
        add_byte({mhp_pkg::PLI_FOUR, id});
        plen = 4;
      end
      3: begin
        plen = $urandom_range(0, 12);
        add_byte({mhp_pkg::PLI_VAR, id});
        add_byte({1'b0, 7'(plen)});
      end
      default: begin
        plen = $urandom_range(0, 12);
        add_byte({mhp_pkg::PLI_VAR, id});
        add_byte({1'b1, 7'(plen >> 8)});
        add_byte(8'(plen));
      end
    endcase
    repeat (plen) add_byte(8'($urandom));
  endtask

  initial begin : stimulus
    request_t    marker;
    int          choice;
    int          ext_len;
    int          plen;
    int          wait_cycles;
    bit          drain_queued;
    logic [12:0] hsize;

    drain_queued = 1'b0;

    // Directed: all-ones core (largest sizes) ending right on the last core byte
    add_core(56'hFF_FFFF_FFFF_FFFF);
    send_frame();
    // all-zero core: header size below the core
    add_core(56'h00_0000_0000_0000);
    send_frame();
    // header that is only a core: empty extension
    add_core({28'h5A5_A5A5, 13'd7, 6'h3F, 9'h000});
    send_frame();
    // buffer that ends inside the core
    add_byte(8'hA5);
    send_frame();
    // 15-bit length field whose second byte would pass the header size
    add_byte({mhp_pkg::PLI_VAR, mhp_pkg::ID_CONTENT_NAME});
    add_byte(8'hFF);
    add_core({28'h000_0000, 13'd9, 6'h00, 9'h1FF});
    send_frame();

    // Random: mostly well-formed headers with random content, mixed with broken ones
    while (request_count < REQUEST_TARGET) begin
      if (!drain_queued && request_count > REQUEST_TARGET / 2) begin
        marker       = '0;
        marker.drain = 1'b1;
        pending_requests = {pending_requests, marker};
        drain_queued = 1'b1;
      end
      choice = $urandom_range(0, 99);
      repeat ($urandom_range(0, 4)) add_param();
      ext_len = frame_bytes.size();
      if (choice < 55) begin
        // well-formed, sometimes with ignored bytes past the header size
        add_core(random_core(13'(mhp_pkg::CORE_BYTES + ext_len)));
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
        send_frame();
      end else if (choice < 63) begin
        // buffer ends inside the core
        frame_bytes.delete();
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
        send_frame();
      end else if (choice < 71) begin
        // header size below the core; the extension bytes become ignored junk
        add_core(random_core(13'($urandom_range(0, 6))));
        send_frame();
      end else if (choice < 83) begin
        // buffer ends before the header size is reached
        hsize = ($urandom_range(0, 7) == 0) ? 13'h1FFF
              : 13'(mhp_pkg::CORE_BYTES + ext_len + $urandom_range(1, 8));
        add_core(random_core(hsize));
        repeat ($urandom_range(0, ext_len)) void'(frame_bytes.pop_back());
        send_frame();
      end else if (choice < 93) begin
        if (ext_len > 0 && $urandom_range(0, 1) == 0) begin
          // header size falls somewhere inside the parameters
          hsize = 13'(mhp_pkg::CORE_BYTES + $urandom_range(0, ext_len - 1));
        end else begin
          // last parameter declares a length that cannot fit
          plen = $urandom_range(1, 32767);
          add_byte({mhp_pkg::PLI_VAR, 6'($urandom)});
          add_byte({1'b1, 7'(plen >> 8)});
          add_byte(8'(plen));
          hsize = 13'(mhp_pkg::CORE_BYTES + frame_bytes.size());
        end
        add_core(random_core(hsize));
        repeat ($urandom_range(0, 2)) add_byte(8'($urandom));
        send_frame();
      end else begin
        // noise: random bytes with random buffer ends, closed by a buffer end
        frame_bytes.delete();
        repeat ($urandom_range(1, 10)) queue_byte(8'($urandom), $urandom_range(0, 3) == 0);
        queue_byte(8'($urandom), 1'b1);
      end
    end

    // Release reset once the stimulus is queued
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to go in, then for every owed result
    while (pending_requests.size() != 0 || in_valid || draining) @(posedge clk);
    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    // quiet period: catch any stray result
    repeat (16) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard limit, far beyond the slowest correct run
  initial begin : watchdog
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
